### rtl/u8n1_pkg.sv
package u8n1_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int BAUD_WIDTH  = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > BAUD_WIDTH) ? COUNT_WIDTH : BAUD_WIDTH;
    localparam int IDX_WIDTH   = 4;

    localparam logic [BAUD_WIDTH-1:0] BAUD_RESET    = 16'd16;
    localparam logic [IDX_WIDTH-1:0]  FRAME_BITS    = 4'd10;
    localparam logic [IDX_WIDTH-1:0]  LAST_DATA_BIT = 4'd9;
    localparam logic [7:0]            TX_IDLE_SHIFT = 8'hFF;

    localparam logic [1:0] STAT_IDLE = 2'd0;
    localparam logic [1:0] STAT_BUSY = 2'd1;
    localparam logic [1:0] STAT_DONE = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [IDX_WIDTH-1:0]   bit_idx_t;

    typedef struct packed {
        logic       rx_level;
        logic       start_send;
        logic [7:0] send_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] rx_status;
        logic [7:0] rx_data;
        logic       tx_level;
        logic [1:0] tx_status;
    } out_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data;
    } rx_result_t;

    typedef struct packed {
        logic       level;
        logic [1:0] status;
    } tx_result_t;

    // True when the incremented tick count closes a bit period
    function automatic logic period_end(input count_t cnt, input logic [BAUD_WIDTH-1:0] limit);
        period_end = CMP_WIDTH'(cnt) >= CMP_WIDTH'(limit);
    endfunction

endpackage

### rtl/uart_8n1_transceiver.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  u8n1_pkg::in_item_t  (one UART clock tick)
// m_        out        m_valid / m_ready  u8n1_pkg::out_item_t (status of that tick)
// cfg_      in         cfg_wr_en          cfg_wr_data = ticks per bit period
//
// One tick is taken per cycle while s_ready is high; its result shows in the output register in the next cycle.
// Receiver and transmitter state advance only on an input transfer, in a single pass.
// s_ready is low only while a result sits in the output register and m_ready is low.
// aresetn is synchronous, active low; it clears both units and sets ticks per bit to 16.
module uart_8n1_transceiver (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  u8n1_pkg::in_item_t               s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output u8n1_pkg::out_item_t              m_item,
    input  logic                             cfg_wr_en,
    input  logic [u8n1_pkg::BAUD_WIDTH-1:0]  cfg_wr_data
);

    logic [u8n1_pkg::BAUD_WIDTH-1:0] baud_reg;
    logic                            m_valid_reg;
    u8n1_pkg::out_item_t             m_item_reg;
    logic                            accept;
    u8n1_pkg::rx_result_t            rx_res;
    u8n1_pkg::tx_result_t            tx_res;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    u8n1_rx u_rx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (accept),
        .rx_level   (s_item.rx_level),
        .bit_ticks  (baud_reg),
        .result     (rx_res)
    );

    u8n1_tx u_tx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (accept),
        .start_send (s_item.start_send),
        .send_byte  (s_item.send_byte),
        .bit_ticks  (baud_reg),
        .result     (tx_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baud_reg    <= u8n1_pkg::BAUD_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                baud_reg <= cfg_wr_data;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg.rx_status <= rx_res.status;
            m_item_reg.rx_data   <= rx_res.data;
            m_item_reg.tx_level  <= tx_res.level;
            m_item_reg.tx_status <= tx_res.status;
        end
    end

`ifndef SYNTH
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("transfer accepted but no result registered");

    a_rx_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.rx_status != u8n1_pkg::STAT_DONE |->
        m_item_reg.rx_data == 8'd0)
        else $error("rx_data nonzero without a completed byte");

    a_tx_idle_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_item_reg.tx_status == u8n1_pkg::STAT_IDLE ||
                        m_item_reg.tx_status == u8n1_pkg::STAT_DONE) |->
        m_item_reg.tx_level)
        else $error("transmit line low while transmitter idle or finishing");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_item_reg.rx_status != 2'd3 && m_item_reg.tx_status != 2'd3)
        else $error("undefined status code in result");
`endif

endmodule

### rtl/u8n1_rx.sv
module u8n1_rx (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             rx_level,
    input  logic [u8n1_pkg::BAUD_WIDTH-1:0]  bit_ticks,
    output u8n1_pkg::rx_result_t             result
);

    logic                busy_reg,  busy_next;
    u8n1_pkg::count_t    cnt_reg,   cnt_next;
    u8n1_pkg::bit_idx_t  idx_reg,   idx_next;
    logic [7:0]          shift_reg, shift_next;

    u8n1_pkg::count_t    cnt_inc;
    u8n1_pkg::bit_idx_t  idx_inc;
    logic [2:0]          dbit;
    logic [u8n1_pkg::BAUD_WIDTH-1:0] half_limit;

    function automatic logic CMP_EQ(input u8n1_pkg::count_t a,
                                    input logic [u8n1_pkg::BAUD_WIDTH-1:0] b);
        CMP_EQ = u8n1_pkg::CMP_WIDTH'(a) == u8n1_pkg::CMP_WIDTH'(b);
    endfunction

    assign cnt_inc    = u8n1_pkg::COUNT_WIDTH'(cnt_reg + 1'b1);
    assign idx_inc    = u8n1_pkg::IDX_WIDTH'(idx_reg + 1'b1);
    assign dbit       = 3'(idx_reg - 1'b1);
    assign half_limit = bit_ticks >> 1;

    always_comb begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        shift_next    = shift_reg;
        result.status = u8n1_pkg::STAT_IDLE;
        result.data   = 8'd0;
        // a low line on an idle receiver already counts as the first start-bit tick
        if (busy_reg || !rx_level) begin
            busy_next     = 1'b1;
            result.status = u8n1_pkg::STAT_BUSY;
            if (u8n1_pkg::period_end(cnt_inc, bit_ticks)) begin
                cnt_next = '0;
                idx_next = idx_inc;
                if (idx_inc == u8n1_pkg::FRAME_BITS) begin
                    result.data   = shift_reg;
                    result.status = u8n1_pkg::STAT_DONE;
                    idx_next      = '0;
                    shift_next    = 8'd0;
                    busy_next     = 1'b0;
                end
            end else begin
                cnt_next = cnt_inc;
                if (idx_reg != '0 && idx_reg < u8n1_pkg::LAST_DATA_BIT &&
                    CMP_EQ(cnt_inc, half_limit)) begin
                    shift_next[dbit] = shift_reg[dbit] | rx_level;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            shift_reg <= 8'd0;
        end else if (en) begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
        end
    end

endmodule

### rtl/u8n1_tx.sv
module u8n1_tx (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             start_send,
    input  logic [7:0]                       send_byte,
    input  logic [u8n1_pkg::BAUD_WIDTH-1:0]  bit_ticks,
    output u8n1_pkg::tx_result_t             result
);

    logic                busy_reg,  busy_next;
    u8n1_pkg::count_t    cnt_reg,   cnt_next;
    u8n1_pkg::bit_idx_t  idx_reg,   idx_next;
    logic [7:0]          shift_reg, shift_next;
    logic                line_reg,  line_next;

    u8n1_pkg::count_t    cnt_inc;
    u8n1_pkg::bit_idx_t  idx_inc;
    logic [2:0]          dbit;

    assign cnt_inc = u8n1_pkg::COUNT_WIDTH'(cnt_reg + 1'b1);
    assign idx_inc = u8n1_pkg::IDX_WIDTH'(idx_reg + 1'b1);
    assign dbit    = 3'(idx_reg - 1'b1);

    always_comb begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        shift_next    = shift_reg;
        line_next     = line_reg;
        result.status = u8n1_pkg::STAT_IDLE;
        if (!busy_reg) begin
            if (start_send) begin
                busy_next  = 1'b1;
                shift_next = send_byte;
            end else begin
                line_next = 1'b1;
            end
        end
        if (busy_next) begin
            result.status = u8n1_pkg::STAT_BUSY;
            if (u8n1_pkg::period_end(cnt_inc, bit_ticks)) begin
                // hold the line level on the tick that closes a bit period
                cnt_next = '0;
                idx_next = idx_inc;
                if (idx_inc == u8n1_pkg::FRAME_BITS) begin
                    busy_next     = 1'b0;
                    idx_next      = '0;
                    shift_next    = u8n1_pkg::TX_IDLE_SHIFT;
                    line_next     = 1'b1;
                    result.status = u8n1_pkg::STAT_DONE;
                end
            end else begin
                cnt_next = cnt_inc;
                if (idx_reg == '0) begin
                    line_next = 1'b0;
                end else if (idx_reg < u8n1_pkg::LAST_DATA_BIT) begin
                    line_next = shift_next[dbit];
                end else begin
                    line_next = 1'b1;
                end
            end
        end
        result.level = line_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            shift_reg <= u8n1_pkg::TX_IDLE_SHIFT;
            line_reg  <= 1'b1;
        end else if (en) begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            line_reg  <= line_next;
        end
    end

endmodule

### tb/tb_uart_8n1_transceiver.sv
class uart_tick_scoreboard;
    logic [u8n1_pkg::BAUD_WIDTH-1:0] baud;
    logic                            rx_busy;
    u8n1_pkg::count_t                rx_ticks;
    u8n1_pkg::bit_idx_t              rx_idx;
    logic [7:0]                      rx_shift;
    logic                            tx_busy;
    u8n1_pkg::count_t                tx_ticks;
    u8n1_pkg::bit_idx_t              tx_idx;
    logic [7:0]                      tx_shift;
    logic                            tx_line;
    u8n1_pkg::out_item_t             pending_q[$];
    int                              errors;

    function new();
        baud     = u8n1_pkg::BAUD_RESET;
        rx_busy  = 1'b0;
        rx_ticks = '0;
        rx_idx   = '0;
        rx_shift = '0;
        tx_busy  = 1'b0;
        tx_ticks = '0;
        tx_idx   = '0;
        tx_shift = u8n1_pkg::TX_IDLE_SHIFT;
        tx_line  = 1'b1;
        errors   = 0;
    endfunction

    function void set_baud(logic [u8n1_pkg::BAUD_WIDTH-1:0] v);
        baud = v;
    endfunction

    // Advance both units by one accepted tick and queue the status it produces
    function void note_tick(u8n1_pkg::in_item_t it);
        u8n1_pkg::out_item_t e;
        e = '0;

        // the tick that leaves idle already counts toward the start bit
        if (!rx_busy && !it.rx_level)
            rx_busy = 1'b1;
        if (rx_busy) begin
            e.rx_status = u8n1_pkg::STAT_BUSY;
            rx_ticks = rx_ticks + 1'b1;
            if (rx_ticks >= baud) begin
                rx_ticks = '0;
                rx_idx = rx_idx + 1'b1;
                if (rx_idx == u8n1_pkg::FRAME_BITS) begin
                    e.rx_data   = rx_shift;
                    e.rx_status = u8n1_pkg::STAT_DONE;
                    rx_idx      = '0;
                    rx_shift    = '0;
                    rx_busy     = 1'b0;
                end
            end else if (rx_idx > 0 && rx_idx < u8n1_pkg::LAST_DATA_BIT &&
                         rx_ticks == (baud >> 1)) begin
                rx_shift = rx_shift | (8'(it.rx_level) << (rx_idx - 1'b1));
            end
        end

        if (!tx_busy) begin
            if (it.start_send) begin
                tx_busy  = 1'b1;
                tx_shift = it.send_byte;
            end else begin
                tx_line = 1'b1;
            end
        end
        if (tx_busy) begin
            e.tx_status = u8n1_pkg::STAT_BUSY;
            tx_ticks = tx_ticks + 1'b1;
            // a tick that closes a bit period leaves the line as it was
            if (tx_ticks >= baud) begin
                tx_ticks = '0;
                tx_idx = tx_idx + 1'b1;
                if (tx_idx == u8n1_pkg::FRAME_BITS) begin
                    tx_busy     = 1'b0;
                    tx_idx      = '0;
                    tx_shift    = u8n1_pkg::TX_IDLE_SHIFT;
                    tx_line     = 1'b1;
                    e.tx_status = u8n1_pkg::STAT_DONE;
                end
            end else if (tx_idx == 0) begin
                tx_line = 1'b0;
            end else if (tx_idx < u8n1_pkg::LAST_DATA_BIT) begin
                tx_line = tx_shift[3'(tx_idx - 1'b1)];
            end else begin
                tx_line = 1'b1;
            end
        end
        e.tx_level = tx_line;
        pending_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_tick(u8n1_pkg::out_item_t got);
        u8n1_pkg::out_item_t want;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected status transfer, expected none got %h", $time, got);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        compare_field("rx_status", 8'(want.rx_status), 8'(got.rx_status));
        compare_field("rx_data", want.rx_data, got.rx_data);
        compare_field("tx_level", 8'(want.tx_level), 8'(got.tx_level));
        compare_field("tx_status", 8'(want.tx_status), 8'(got.tx_status));
    endfunction

    function bit drained();
        return pending_q.size() == 0;
    endfunction
endclass

module tb_uart_8n1_transceiver;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_valid     = 1'b0;
    logic                            s_ready;
    u8n1_pkg::in_item_t              s_item      = '0;
    logic                            m_valid;
    logic                            m_ready     = 1'b1;
    u8n1_pkg::out_item_t             m_item;
    logic                            cfg_wr_en   = 1'b0;
    logic [u8n1_pkg::BAUD_WIDTH-1:0] cfg_wr_data = '0;

    int unsigned                     gap_pct     = 0;
    int unsigned                     stall_pct   = 0;
    logic [u8n1_pkg::BAUD_WIDTH-1:0] cur_baud    = u8n1_pkg::BAUD_RESET;
    logic                            rx_wave[$];
    uart_tick_scoreboard             sb;

    uart_8n1_transceiver u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_tick(m_item);
    end

    initial begin
        #2000000;
        $display("uart_8n1_transceiver regression: fail");
        $finish;
    end

    task automatic send_tick(input u8n1_pkg::in_item_t it);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(it);
    endtask

    // Hold the input side until every queued status has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (!sb.drained())
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_baud(input logic [u8n1_pkg::BAUD_WIDTH-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_baud(v);
        cur_baud = v;
    endtask

    // Queue receive line levels: mostly whole frames, some cut short, some noise
    task automatic refill_rx_wave();
        int unsigned period;
        int unsigned pick;
        int unsigned nbits;
        logic [7:0]  data;
        logic        lvl;
        period = (cur_baud == 0) ? 1 : ((cur_baud > 24) ? 24 : cur_baud);
        pick   = $urandom_range(99);
        data   = 8'($urandom);
        if (pick < 80) begin
            nbits = (pick < 68) ? 10 : $urandom_range(1, 9);
            for (int k = 0; k < nbits; k++) begin
                lvl = (k == 0) ? 1'b0 : ((k == 9) ? 1'b1 : data[k - 1]);
                repeat (period) rx_wave.push_back(lvl);
            end
        end else begin
            repeat ($urandom_range(1, 6)) rx_wave.push_back(1'($urandom_range(1)));
        end
        repeat ($urandom_range(0, 2 * period)) rx_wave.push_back(1'b1);
    endtask

    task automatic run_phase(input logic [u8n1_pkg::BAUD_WIDTH-1:0] baud, input int n_ticks,
                             input int unsigned gap, input int unsigned stall,
                             input int pause_at);
        u8n1_pkg::in_item_t it;
        write_baud(baud);
        gap_pct   = gap;
        stall_pct = stall;
        rx_wave.delete();
        for (int i = 0; i < n_ticks; i++) begin
            if (i == pause_at)
                drain();
            if (rx_wave.size() == 0)
                refill_rx_wave();
            it.rx_level   = rx_wave.pop_front();
            it.start_send = ($urandom_range(3) == 0);
            it.send_byte  = 8'($urandom);
            send_tick(it);
        end
        drain();
    endtask

    initial begin
        u8n1_pkg::in_item_t it;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: same-tick start on both sides, 0x00 sent, a request while
        // busy with a different byte, then 0xFF after the frame closes
        write_baud(16'd2);
        for (int i = 0; i < 24; i++) begin
            it.rx_level   = (i == 0 || i == 21) ? 1'b0 : (i < 12);
            it.start_send = (i == 0 || i == 4 || i == 21);
            it.send_byte  = (i == 0) ? 8'h00 : ((i == 4) ? 8'h3C : 8'hFF);
            send_tick(it);
        end
        drain();

        run_phase(16'd1,    150, 0,  0,  -1);
        run_phase(16'd3,    200, 58, 0,  -1);
        run_phase(16'd2,    200, 0,  58, -1);
        run_phase(16'd5,    250, 35, 35, 120);
        run_phase(16'd0,    40,  0,  0,  -1);
        run_phase(16'd4,    200, 58, 0,  -1);
        run_phase(16'hFFFF, 60,  35, 35, -1);
        run_phase(16'd7,    250, 0,  58, -1);
        run_phase(16'd16,   300, 35, 35, -1);

        if (sb.errors == 0 && sb.drained())
            $display("uart_8n1_transceiver regression: pass");
        else
            $display("uart_8n1_transceiver regression: fail");
        $finish;
    end

endmodule
